### rtl/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg: shared types for the loopback packet ring pair
// Request and result payloads, status codes and action codes.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int RING_COUNT = 2;

  typedef enum logic {
    ACT_SEND = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_TAKEN  = 3'd0,
    ST_COMMIT = 3'd1,
    ST_DROP   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_BYTE   = 3'd4,
    ST_ZERO   = 3'd5,
    ST_LONG   = 3'd6,
    ST_LOST   = 3'd7
  } status_t;

  typedef struct packed {
    action_t     action;
    logic        endpoint;
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last;
    logic [6:0]  receive_limit;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_byte;
    logic        out_last;
    logic [6:0]  packet_length;
  } out_item_t;

endpackage

### rtl/loopback_packet_ring_pair.sv
// ----------------------------------------------------------------------------
// loopback_packet_ring_pair: two endpoints exchanging packets through rings
// Each endpoint sends bytes into its peer's ring and reads its own ring.
// ----------------------------------------------------------------------------
//
//   channel  | ports                          | moves
//   ---------+--------------------------------+------------------------------
//   request  | in_valid, in_stall, in_item    | one send or read byte action
//   result   | out_valid, out_stall, out_item | one status per request
//
// One request per cycle, sustained while the result is not stalled. An accepted
// request is held in the request register, worked out of it, and lands in the
// result register once that register can take it. The head byte and head
// length of each ring are prefetched every cycle from that ring's storage
// (registered read, write forwarded), so a read never waits on memory. Reset
// clears control state only; storage needs no clearing pass. A stalled result
// holds the request register, which then raises in_stall; otherwise requests
// flow straight through.
//
module loopback_packet_ring_pair import lpr_pkg::*; #(
  parameter int SLOT_COUNT   = 16,
  parameter int PACKET_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic      req_valid_r;
  in_item_t  req_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;

  logic      advance;
  logic      fire;
  logic      accept;
  out_item_t result;

  // result register can take a new result when empty or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign fire     = req_valid_r && advance;
  // hold the request register while its result cannot move on
  assign in_stall = req_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        req_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  lpr_engine #(
    .SLOT_COUNT   (SLOT_COUNT),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (req_item_r),
    .result (result)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### rtl/lpr_ring_mem.sv
// ----------------------------------------------------------------------------
// lpr_ring_mem: packet byte and length storage of one ring
// One write and one registered read port per store, with write forwarding.
// ----------------------------------------------------------------------------
module lpr_ring_mem #(
  parameter int SLOT_COUNT   = 16,
  parameter int PACKET_BYTES = 64
) (
  input  logic                                   clk,
  input  logic                                   byte_we,
  input  logic [$clog2(SLOT_COUNT)-1:0]          byte_wslot,
  input  logic [((PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1)-1:0] byte_woff,
  input  logic [7:0]                             byte_wdata,
  input  logic                                   len_we,
  input  logic [$clog2(SLOT_COUNT)-1:0]          len_wslot,
  input  logic [$clog2(PACKET_BYTES+1)-1:0]      len_wdata,
  input  logic [$clog2(SLOT_COUNT)-1:0]          rd_slot,
  input  logic [((PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1)-1:0] rd_off,
  output logic [7:0]                             rd_byte,
  output logic [$clog2(PACKET_BYTES+1)-1:0]      rd_len
);

  localparam int LW = $clog2(PACKET_BYTES + 1);

  logic [7:0]    byte_mem [SLOT_COUNT][PACKET_BYTES];
  logic [LW-1:0] len_mem  [SLOT_COUNT];

  logic [7:0]    byte_q_r;
  logic          byte_fwd_r;
  logic [7:0]    byte_fwd_data_r;
  logic [LW-1:0] len_q_r;
  logic          len_fwd_r;
  logic [LW-1:0] len_fwd_data_r;

  always_ff @(posedge clk) begin
    if (byte_we) begin
      byte_mem[byte_wslot][byte_woff] <= byte_wdata;
    end
    byte_q_r        <= byte_mem[rd_slot][rd_off];
    byte_fwd_r      <= byte_we && (byte_wslot == rd_slot) && (byte_woff == rd_off);
    byte_fwd_data_r <= byte_wdata;
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_wslot] <= len_wdata;
    end
    len_q_r        <= len_mem[rd_slot];
    len_fwd_r      <= len_we && (len_wslot == rd_slot);
    len_fwd_data_r <= len_wdata;
  end

  assign rd_byte = byte_fwd_r ? byte_fwd_data_r : byte_q_r;
  assign rd_len  = len_fwd_r ? len_fwd_data_r : len_q_r;

endmodule

### rtl/lpr_engine.sv
// ----------------------------------------------------------------------------
// lpr_engine: per-item ring update and result formation
// Holds the ring control state and prefetches each ring's head byte/length.
// ----------------------------------------------------------------------------
module lpr_engine import lpr_pkg::*; #(
  parameter int SLOT_COUNT   = 16,
  parameter int PACKET_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  output out_item_t result
);

  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int HW  = SW + 1;
  localparam int OCW = $clog2(SLOT_COUNT + 1);
  localparam int OW  = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
  localparam int LW  = $clog2(PACKET_BYTES + 1);
  localparam int CW  = (LW > 7) ? LW : 7;

  localparam logic [SW-1:0]  SLOT_LAST = SW'(SLOT_COUNT - 1);
  localparam logic [HW-1:0]  SLOT_SPAN = HW'(SLOT_COUNT);
  localparam logic [OCW-1:0] OCC_FULL  = OCW'(SLOT_COUNT);
  localparam logic [LW-1:0]  LEN_MAX   = LW'(PACKET_BYTES);

  // ring control state
  logic [SW-1:0]  send_slot_r [RING_COUNT];
  logic [OCW-1:0] occ_r       [RING_COUNT];
  logic [LW-1:0]  woff_r      [RING_COUNT];
  logic           werr_r      [RING_COUNT];
  logic [LW-1:0]  roff_r      [RING_COUNT];
  logic           active_r    [RING_COUNT];
  logic           lost_r      [RING_COUNT];

  logic [SW-1:0]  send_slot_nxt [RING_COUNT];
  logic [OCW-1:0] occ_nxt       [RING_COUNT];
  logic [LW-1:0]  woff_nxt      [RING_COUNT];
  logic           werr_nxt      [RING_COUNT];
  logic [LW-1:0]  roff_nxt      [RING_COUNT];
  logic           active_nxt    [RING_COUNT];
  logic           lost_nxt      [RING_COUNT];

  // storage interface, one per ring
  logic           byte_we  [RING_COUNT];
  logic           len_we   [RING_COUNT];
  logic [SW-1:0]  rd_slot  [RING_COUNT];
  logic [OW-1:0]  rd_off   [RING_COUNT];
  logic [7:0]     rd_byte  [RING_COUNT];
  logic [LW-1:0]  rd_len   [RING_COUNT];
  logic [HW-1:0]  head_sum [RING_COUNT];

  // values of the addressed ring after this item
  logic           ring;
  logic [SW-1:0]  slot_c;
  logic [SW-1:0]  slot_n;
  logic [OCW-1:0] occ_n;
  logic [LW-1:0]  woff_n;
  logic           werr_n;
  logic [LW-1:0]  roff_n;
  logic           act_n;
  logic           lost_n;
  logic           claim_c;
  logic           start_c;
  logic           bwe_c;
  logic [OW-1:0]  bwoff_c;
  logic           lwe_c;
  logic [LW-1:0]  lval_c;
  logic [LW-1:0]  len_c;
  logic [CW-1:0]  len_ext_c;

  assign ring   = (item.action == ACT_SEND) ? ~item.endpoint : item.endpoint;
  assign slot_c = send_slot_r[ring];
  assign len_c  = rd_len[ring];

  always_comb begin
    slot_n    = slot_c;
    occ_n     = occ_r[ring];
    woff_n    = woff_r[ring];
    werr_n    = werr_r[ring];
    roff_n    = roff_r[ring];
    act_n     = active_r[ring];
    lost_n    = lost_r[ring];
    claim_c   = 1'b0;
    start_c   = 1'b0;
    bwe_c     = 1'b0;
    bwoff_c   = woff_r[ring][OW-1:0];
    lwe_c     = 1'b0;
    lval_c    = woff_r[ring];
    len_ext_c = CW'(len_c);
    result    = '0;
    result.status = ST_TAKEN;

    if (item.action == ACT_SEND) begin
      // claim the slot at the first stored byte, or at commit of an empty packet
      claim_c = (woff_n == '0) && (item.byte_valid || item.last);
      if (claim_c && (occ_n == OCC_FULL)) begin
        occ_n = OCC_FULL - 1'b1;
        if (act_n) begin
          act_n  = 1'b0;
          roff_n = '0;
          lost_n = 1'b1;
        end
      end
      if (item.byte_valid) begin
        if (woff_n < LEN_MAX) begin
          bwe_c   = 1'b1;
          bwoff_c = woff_n[OW-1:0];
          woff_n  = woff_n + 1'b1;
        end else begin
          werr_n = 1'b1;
        end
      end
      if (item.last) begin
        if (werr_n) begin
          result.status = ST_DROP;
        end else begin
          lwe_c  = 1'b1;
          lval_c = woff_n;
          slot_n = (slot_n == SLOT_LAST) ? '0 : slot_n + 1'b1;
          occ_n  = occ_n + 1'b1;
          result.status = ST_COMMIT;
        end
        woff_n = '0;
        werr_n = 1'b0;
      end
    end else begin
      if (lost_n) begin
        lost_n = 1'b0;
        result.status = ST_LOST;
      end else if (!act_n && (occ_n == '0)) begin
        result.status = ST_EMPTY;
      end else begin
        result.packet_length = len_ext_c[6:0];
        start_c = 1'b1;
        if (!act_n) begin
          if (len_c == '0) begin
            occ_n   = occ_n - 1'b1;
            start_c = 1'b0;
            result.status = ST_ZERO;
          end else if (len_ext_c > CW'(item.receive_limit)) begin
            occ_n   = occ_n - 1'b1;
            start_c = 1'b0;
            result.status = ST_LONG;
          end else begin
            act_n = 1'b1;
          end
        end
        if (start_c) begin
          result.status   = ST_BYTE;
          result.out_byte = rd_byte[ring];
          if ((roff_n + 1'b1) >= len_c) begin
            result.out_last = 1'b1;
            occ_n  = occ_n - 1'b1;
            act_n  = 1'b0;
            roff_n = '0;
          end else begin
            roff_n = roff_n + 1'b1;
          end
        end
      end
    end
  end

  // next state per ring; prefetch at the head that the next item will see
  always_comb begin
    for (int i = 0; i < RING_COUNT; i++) begin
      if (fire && (ring == 1'(i))) begin
        send_slot_nxt[i] = slot_n;
        occ_nxt[i]       = occ_n;
        woff_nxt[i]      = woff_n;
        werr_nxt[i]      = werr_n;
        roff_nxt[i]      = roff_n;
        active_nxt[i]    = act_n;
        lost_nxt[i]      = lost_n;
        byte_we[i]       = bwe_c;
        len_we[i]        = lwe_c;
      end else begin
        send_slot_nxt[i] = send_slot_r[i];
        occ_nxt[i]       = occ_r[i];
        woff_nxt[i]      = woff_r[i];
        werr_nxt[i]      = werr_r[i];
        roff_nxt[i]      = roff_r[i];
        active_nxt[i]    = active_r[i];
        lost_nxt[i]      = lost_r[i];
        byte_we[i]       = 1'b0;
        len_we[i]        = 1'b0;
      end
      head_sum[i] = HW'(send_slot_nxt[i]) + SLOT_SPAN - HW'(occ_nxt[i]);
      if (head_sum[i] >= SLOT_SPAN) begin
        head_sum[i] = head_sum[i] - SLOT_SPAN;
      end
      rd_slot[i] = head_sum[i][SW-1:0];
      rd_off[i]  = roff_nxt[i][OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RING_COUNT; i++) begin
        send_slot_r[i] <= '0;
        occ_r[i]       <= '0;
        woff_r[i]      <= '0;
        werr_r[i]      <= 1'b0;
        roff_r[i]      <= '0;
        active_r[i]    <= 1'b0;
        lost_r[i]      <= 1'b0;
      end
    end else begin
      for (int i = 0; i < RING_COUNT; i++) begin
        send_slot_r[i] <= send_slot_nxt[i];
        occ_r[i]       <= occ_nxt[i];
        woff_r[i]      <= woff_nxt[i];
        werr_r[i]      <= werr_nxt[i];
        roff_r[i]      <= roff_nxt[i];
        active_r[i]    <= active_nxt[i];
        lost_r[i]      <= lost_nxt[i];
      end
    end
  end

  for (genvar g = 0; g < RING_COUNT; g++) begin : g_ring
    lpr_ring_mem #(
      .SLOT_COUNT   (SLOT_COUNT),
      .PACKET_BYTES (PACKET_BYTES)
    ) u_mem (
      .clk        (clk),
      .byte_we    (byte_we[g]),
      .byte_wslot (slot_c),
      .byte_woff  (bwoff_c),
      .byte_wdata (item.data_byte),
      .len_we     (len_we[g]),
      .len_wslot  (slot_c),
      .len_wdata  (lval_c),
      .rd_slot    (rd_slot[g]),
      .rd_off     (rd_off[g]),
      .rd_byte    (rd_byte[g]),
      .rd_len     (rd_len[g])
    );
  end

endmodule
